// ===== rtl/core/cps_pkg.sv =====
// Shared types and constants for the contactor precharge sequencer.
// Used by every module of the block; depends on nothing.
package cps_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_OPEN  = 2'd2;

  localparam logic [2:0] REG_TICK_PERIOD   = 3'd0;
  localparam logic [2:0] REG_NEG_DELAY     = 3'd1;
  localparam logic [2:0] REG_POS_DELAY     = 3'd2;
  localparam logic [2:0] REG_PRE_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_RATIO         = 3'd4;
  localparam logic [2:0] REG_SIM_PRECHARGE = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] RELAY_OFF = 3'b000;
  localparam logic [2:0] RELAY_NEG = 3'b001;
  localparam logic [2:0] RELAY_PRE = 3'b010;
  localparam logic [2:0] RELAY_POS = 3'b100;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CLOSE,
    OP_OPEN
  } op_t;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_NEG     = 3'd1,
    ST_PRE     = 3'd2,
    ST_POS     = 3'd3,
    ST_RUN     = 3'd4,
    ST_OPENING = 3'd5,
    ST_FAULT   = 3'd6
  } pack_state_t;

  typedef struct packed {
    op_t  op;
    logic pack;
    logic fault;
    logic volt_ok;
  } qentry_t;

  typedef struct packed {
    logic [9:0]  tick_period_ms;
    logic [15:0] negative_delay_ms;
    logic [15:0] positive_delay_ms;
    logic [15:0] precharge_timeout_ms;
    logic [8:0]  complete_ratio_q8;
    logic        simulated_precharge;
  } cfg_t;

endpackage

// ===== rtl/core/cps_front.sv =====
// Front end: accepts input transfers, drops items that give no effect and
// classifies the rest, including the bus voltage judgement. Uses cps_pkg.
module cps_front #(
  parameter int PACKS = 2
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic              pack,
  input  logic              pack_fault,
  input  logic              system_fault,
  input  logic [13:0]       pack_voltage,
  input  logic [13:0]       bus_voltage,
  input  logic [8:0]        ratio_q8,
  input  logic              q_full,
  output logic              push,
  output cps_pkg::qentry_t  entry
);
  import cps_pkg::*;

  logic [22:0] lhs;
  logic [22:0] rhs;
  logic        kind_ok;
  logic        pack_ok;

  assign lhs = {1'b0, bus_voltage, 8'b0};
  assign rhs = {9'b0, pack_voltage} * {14'b0, ratio_q8};

  assign in_ready = !q_full;
  assign kind_ok  = (kind == KIND_TICK) || (kind == KIND_CLOSE) || (kind == KIND_OPEN);
  assign pack_ok  = (32'(pack) < PACKS);
  assign push     = in_valid && in_ready && kind_ok && pack_ok;

  always_comb begin
    case (kind)
      KIND_CLOSE: entry.op = OP_CLOSE;
      KIND_OPEN:  entry.op = OP_OPEN;
      default:    entry.op = OP_TICK;
    endcase
    entry.pack    = pack;
    entry.fault   = pack_fault || system_fault;
    entry.volt_ok = (pack_voltage != 14'd0) && (lhs >= rhs);
  end

endmodule

// ===== rtl/core/cps_queue.sv =====
// Short queue of classified items between the front and back ends.
// Uses cps_pkg for the entry type and depth.
module cps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cps_pkg::qentry_t  wr_entry,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output cps_pkg::qentry_t  rd_entry
);
  import cps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_valid  = (count != '0);
  assign q_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_entry = mem[rd_ptr];
  assign do_push  = push && !q_full;
  assign do_pop   = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cps_back.sv =====
// Back end: per-pack sequencer state, request latches and the registered
// result stage. Uses cps_pkg for the entry, configuration and state types.
module cps_back #(
  parameter int PACKS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  cps_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  cps_pkg::qentry_t  q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_pack,
  output logic [2:0]        state_code,
  output logic              negative_on,
  output logic              precharge_on,
  output logic              positive_on,
  output logic              timeout_fault
);
  import cps_pkg::*;

  localparam int PIDX_W = (PACKS > 1) ? $clog2(PACKS) : 1;

  pack_state_t  state_arr [PACKS];
  logic [15:0]  timer_arr [PACKS];
  logic         close_arr [PACKS];
  logic         open_arr  [PACKS];
  logic [2:0]   drive_arr [PACKS];

  logic [PIDX_W-1:0] idx;
  pack_state_t       st_cur;
  pack_state_t       st_next;
  logic [15:0]       tm_adv;
  logic [15:0]       tm_next;
  logic [16:0]       tm_sum;
  logic              cl_next;
  logic              op_next;
  logic [2:0]        dr_next;
  logic              tout;
  logic              is_tick;

  assign idx     = PIDX_W'(q_entry.pack);
  assign st_cur  = state_arr[idx];
  assign pop     = q_valid && (!out_valid || out_ready);
  assign is_tick = (q_entry.op == OP_TICK);
  assign tm_sum  = {1'b0, timer_arr[idx]} + {7'b0, cfg.tick_period_ms};

  always_comb begin
    st_next = st_cur;
    cl_next = close_arr[idx];
    op_next = open_arr[idx];
    dr_next = drive_arr[idx];
    tout    = 1'b0;
    if ((st_cur == ST_NEG) || (st_cur == ST_PRE) || (st_cur == ST_POS)) begin
      tm_adv = tm_sum[16] ? 16'hFFFF : tm_sum[15:0];
    end else begin
      tm_adv = timer_arr[idx];
    end
    tm_next = timer_arr[idx];
    case (q_entry.op)
      OP_CLOSE: begin
        cl_next = 1'b1;
        op_next = 1'b0;
      end
      OP_OPEN: begin
        op_next = 1'b1;
        cl_next = 1'b0;
      end
      default: begin
        tm_next = tm_adv;
        if (q_entry.fault) begin
          dr_next = RELAY_OFF;
          cl_next = 1'b0;
          op_next = 1'b0;
          st_next = ST_FAULT;
        end else if (open_arr[idx]) begin
          dr_next = RELAY_OFF;
          op_next = 1'b0;
          st_next = ST_OFF;
        end else begin
          case (st_cur)
            ST_OFF: begin
              dr_next = RELAY_OFF;
              if (close_arr[idx]) begin
                cl_next = 1'b0;
                dr_next = RELAY_NEG;
                st_next = ST_NEG;
              end
            end
            ST_NEG: begin
              dr_next = drive_arr[idx] | RELAY_NEG;
              if (tm_adv >= cfg.negative_delay_ms) begin
                dr_next = drive_arr[idx] | RELAY_NEG | RELAY_PRE;
                st_next = ST_PRE;
              end
            end
            ST_PRE: begin
              dr_next = RELAY_NEG | RELAY_PRE;
              if (cfg.simulated_precharge) begin
                if (tm_adv >= cfg.positive_delay_ms) begin
                  dr_next = RELAY_NEG | RELAY_PRE | RELAY_POS;
                  st_next = ST_POS;
                end
              end else if (q_entry.volt_ok) begin
                dr_next = RELAY_NEG | RELAY_PRE | RELAY_POS;
                st_next = ST_POS;
              end else if (tm_adv >= cfg.precharge_timeout_ms) begin
                tout = 1'b1;
              end
            end
            ST_POS: begin
              dr_next = RELAY_NEG | RELAY_PRE | RELAY_POS;
              if (tm_adv >= cfg.positive_delay_ms) begin
                dr_next = RELAY_NEG | RELAY_POS;
                st_next = ST_RUN;
              end
            end
            ST_RUN: begin
              dr_next = RELAY_NEG | RELAY_POS;
            end
            ST_OPENING, ST_FAULT: begin
              dr_next = RELAY_OFF;
              st_next = ST_OFF;
            end
            default: begin
              dr_next = RELAY_OFF;
              st_next = ST_FAULT;
            end
          endcase
        end
        if (st_next != st_cur || q_entry.fault || open_arr[idx]) begin
          tm_next = 16'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PACKS; i++) begin
        state_arr[i] <= ST_OFF;
        timer_arr[i] <= 16'd0;
        close_arr[i] <= 1'b0;
        open_arr[i]  <= 1'b0;
        drive_arr[i] <= RELAY_OFF;
      end
    end else if (pop) begin
      state_arr[idx] <= st_next;
      timer_arr[idx] <= tm_next;
      close_arr[idx] <= cl_next;
      open_arr[idx]  <= op_next;
      drive_arr[idx] <= dr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_tick) begin
      result_pack   <= q_entry.pack;
      state_code    <= st_next;
      negative_on   <= dr_next[0];
      precharge_on  <= dr_next[1];
      positive_on   <= dr_next[2];
      timeout_fault <= tout;
    end
  end

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop && is_tick |=> out_valid)
    else $error("tick transfer did not produce a result");

  a_run_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (state_code == ST_RUN) |->
      negative_on && positive_on && !precharge_on)
    else $error("run state with wrong relay drive");

  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((state_code == ST_OFF) || (state_code == ST_FAULT)) |->
      !negative_on && !precharge_on && !positive_on)
    else $error("relays driven while off or faulted");

  a_timeout_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_fault |-> (state_code == ST_PRE))
    else $error("timeout flagged outside precharge");

endmodule

// ===== rtl/core/contactor_precharge_sequencer.sv =====
// Top level of the contactor precharge sequencer: configuration registers
// and the front end, queue and back end. Uses cps_pkg, cps_front, cps_queue
// and cps_back.
//
// Input items arrive on a valid/ready channel: a tick for one pack, or a
// close or open request. Requests and ticks for a pack beyond PACKS, and the
// unused kind code, produce no result; every tick produces one result.
// The block takes one item per cycle while the queue is not full. A tick
// goes through the queue into the registered result stage while the
// receiver keeps up; behind a stalled receiver it waits in the queue.
// When the receiver stalls, the result register holds and the two-entry
// queue absorbs items; in_ready drops only when the queue is full.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and must
// be written while the block is idle; unknown indexes are ignored.
// Reset puts every pack in off with relays open, clears the latched
// requests and timers, and loads the default configuration.
module contactor_precharge_sequencer #(
  parameter int PACKS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic        pack,
  input  logic        pack_fault,
  input  logic        system_fault,
  input  logic [13:0] pack_voltage,
  input  logic [13:0] bus_voltage,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_pack,
  output logic [2:0]  state_code,
  output logic        negative_on,
  output logic        precharge_on,
  output logic        positive_on,
  output logic        timeout_fault,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cps_pkg::*;

  cfg_t    cfg;
  qentry_t wr_entry;
  qentry_t rd_entry;
  logic    push;
  logic    pop;
  logic    q_valid;
  logic    q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms       <= 10'd10;
      cfg.negative_delay_ms    <= 16'd100;
      cfg.positive_delay_ms    <= 16'd100;
      cfg.precharge_timeout_ms <= 16'd5000;
      cfg.complete_ratio_q8    <= 9'd243;
      cfg.simulated_precharge  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_PERIOD:   cfg.tick_period_ms       <= cfg_data[9:0];
        REG_NEG_DELAY:     cfg.negative_delay_ms    <= cfg_data;
        REG_POS_DELAY:     cfg.positive_delay_ms    <= cfg_data;
        REG_PRE_TIMEOUT:   cfg.precharge_timeout_ms <= cfg_data;
        REG_RATIO:         cfg.complete_ratio_q8    <= cfg_data[8:0];
        REG_SIM_PRECHARGE: cfg.simulated_precharge  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cps_front #(.PACKS(PACKS)) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .pack         (pack),
    .pack_fault   (pack_fault),
    .system_fault (system_fault),
    .pack_voltage (pack_voltage),
    .bus_voltage  (bus_voltage),
    .ratio_q8     (cfg.complete_ratio_q8),
    .q_full       (q_full),
    .push         (push),
    .entry        (wr_entry)
  );

  cps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .rd_entry (rd_entry)
  );

  cps_back #(.PACKS(PACKS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_entry       (rd_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_pack   (result_pack),
    .state_code    (state_code),
    .negative_on   (negative_on),
    .precharge_on  (precharge_on),
    .positive_on   (positive_on),
    .timeout_fault (timeout_fault)
  );

endmodule
